>>> rtl/slra_pkg.sv
// ============================================================================
// slra_pkg: shared types and constants of the spatial lag row average core
// Transaction payloads, register indexes and the command and status bundles
// that pass between the row controller and the row datapath.
// ============================================================================
package slra_pkg;

   // Fixed field widths
   localparam int unsigned NID_W   = 16;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned WGT_W   = 32;
   localparam int unsigned SUM_W   = 64;
   localparam int unsigned WT_W    = 48;
   localparam int unsigned USED_W  = 9;
   localparam int unsigned QBITS   = 64;
   localparam int unsigned STEP_W  = 6;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BINARY_MODE  = 1'b0,
      REG_EXCLUDE_SELF = 1'b1
   } csr_index_type;

   // One neighbour element of a row
   typedef struct packed {
      logic [NID_W-1:0]        neighbor_id;
      logic signed [VAL_W-1:0] neighbor_value;
      logic [WGT_W-1:0]        neighbor_weight;
      logic [NID_W-1:0]        row_id;
      logic                    empty_row;
      logic                    last_element;
   } slra_req_type;

   // One row result
   typedef struct packed {
      logic signed [VAL_W-1:0] lag_value;
      logic [USED_W-1:0]       used_count;
      logic                    zero_divisor;
   } slra_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;     // latch the accepted transaction
      logic multiply;    // form the product and the use flag
      logic accumulate;  // add into the row accumulators
      logic div_setup;   // load dividend and divisor into the divider
      logic div_step;    // one restoring division step
      logic load_out;    // finalise the quotient into the output register and clear the row
   } slra_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic empty_row;
      logic last_element;
   } slra_status_type;

endpackage

>>> rtl/slra_ctrl.sv
// ============================================================================
// slra_ctrl: row controller
// Sequences each transaction through multiply, accumulate and, at row end, the
// bit-serial division (an empty row skips to the result); owns the result valid flag.
// ============================================================================
module slra_ctrl
   import slra_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output slra_cmd_type    cmd,
   input  slra_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DIV_SETUP,
      ST_DIV_RUN,
      ST_EMIT
   } state_type;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QBITS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   // The output register may be loaded when empty or when its transaction leaves now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state, step counter and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = status.empty_row ? ST_EMIT : ST_ACC;
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = status.last_element ? ST_DIV_SETUP : ST_IDLE;
         end
         ST_DIV_SETUP: begin
            cmd.div_setup = 1'b1;
            step_in       = '0;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/slra_dp.sv
// ============================================================================
// slra_dp: row datapath
// Configuration registers, element register, product register, saturating
// row accumulators, a restoring divider one quotient bit per cycle and the
// result register.
// ============================================================================
module slra_dp
   import slra_pkg::*;
#(
   parameter int unsigned ID_WIDTH      = 16,
   parameter int unsigned MAX_NEIGHBORS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  slra_req_type         req_data,
   input  slra_cmd_type         cmd,
   output slra_status_type      status,
   output slra_rsp_type         rsp_data
);

   localparam int unsigned CMP_W = (ID_WIDTH < NID_W) ? ID_WIDTH : NID_W;
   localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_NEIGHBORS);
   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [QBITS-1:0] POS_LIMIT = QBITS'(32'h7FFF_FFFF);
   localparam logic [QBITS-1:0] NEG_LIMIT = QBITS'(32'h8000_0000);

   // Configuration registers
   logic binary_mode_ff;
   logic exclude_self_ff;

   // Element and product stage
   slra_req_type            item_ff;
   logic                    item_binary_ff;
   logic                    item_exclude_ff;
   logic signed [SUM_W-1:0] prod_ff;
   logic                    use_ff;

   // Row accumulators
   logic signed [SUM_W-1:0] sum_ff;
   logic [WT_W-1:0]         wt_ff;
   logic [CNT_W-1:0]        count_ff;

   // Divider
   logic [QBITS-1:0] quo_ff;
   logic [WT_W-1:0]  rem_ff;
   logic [WT_W-1:0]  den_ff;
   logic             neg_ff;
   logic             zero_ff;
   logic [USED_W-1:0] used_ff;

   // Result register
   slra_rsp_type rsp_ff;

   logic signed [VAL_W:0]   val_ext;
   logic signed [WGT_W:0]   wgt_ext;
   logic signed [VAL_W+WGT_W+1:0] prod_full;
   logic                    id_match;
   logic [SUM_W:0]          sum_wide;
   logic [SUM_W-1:0]        sum_sat;
   logic [WT_W:0]           wt_wide;
   logic [WT_W-1:0]         wt_sat;
   logic [WT_W-1:0]         den_pick;
   logic [WT_W:0]           trial;
   logic                    fits;
   logic [31:0]             count_wide;
   logic [QBITS-1:0]        mag_sat;
   logic [QBITS-1:0]        q_signed;

   assign status.empty_row    = item_ff.empty_row;
   assign status.last_element = item_ff.last_element;
   assign rsp_data            = rsp_ff;

   // Product operands and self test
   assign val_ext   = {item_ff.neighbor_value[VAL_W-1], item_ff.neighbor_value};
   assign wgt_ext   = {1'b0, item_ff.neighbor_weight};
   assign prod_full = val_ext * wgt_ext;
   assign id_match  = (item_ff.neighbor_id[CMP_W-1:0] == item_ff.row_id[CMP_W-1:0]);

   // Saturating accumulation
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff} + {prod_ff[SUM_W-1], prod_ff};
   assign sum_sat  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                     ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];
   assign wt_wide  = {1'b0, wt_ff} + (WT_W+1)'(item_ff.neighbor_weight);
   assign wt_sat   = wt_wide[WT_W] ? {WT_W{1'b1}} : wt_wide[WT_W-1:0];

   // Divisor choice and used count clamp
   assign den_pick   = item_binary_ff ? WT_W'(count_ff) : wt_ff;
   assign count_wide = 32'(count_ff);

   // Restoring division step
   assign trial = {rem_ff, quo_ff[QBITS-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   // Quotient saturation and sign
   always_comb begin
      if (neg_ff) begin
         mag_sat = (quo_ff > NEG_LIMIT) ? NEG_LIMIT : quo_ff;
      end else begin
         mag_sat = (quo_ff > POS_LIMIT) ? POS_LIMIT : quo_ff;
      end
      q_signed = neg_ff ? (QBITS'(0) - mag_sat) : mag_sat;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff  <= 1'b0;
         exclude_self_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_BINARY_MODE:  binary_mode_ff  <= csr_wdata[0];
            REG_EXCLUDE_SELF: exclude_self_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Element capture and product stage
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff         <= req_data;
         item_binary_ff  <= binary_mode_ff;
         item_exclude_ff <= exclude_self_ff;
      end
      if (cmd.multiply) begin
         prod_ff <= item_binary_ff ? SUM_W'(val_ext) : $signed(prod_full[SUM_W-1:0]);
         use_ff  <= !(item_exclude_ff && id_match) && (count_ff < CNT_LIMIT);
      end
   end

   // Row accumulators: cleared when a result is loaded
   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         sum_ff   <= '0;
         wt_ff    <= '0;
         count_ff <= '0;
      end else if (cmd.accumulate && use_ff) begin
         sum_ff   <= sum_sat;
         wt_ff    <= wt_sat;
         count_ff <= count_ff + 1'b1;
      end
   end

   // Divider: magnitude shifts out of the top of quo_ff while quotient bits enter below
   always_ff @(posedge clock) begin
      if (cmd.div_setup) begin
         neg_ff  <= sum_ff[SUM_W-1];
         quo_ff  <= sum_ff[SUM_W-1] ? (QBITS'(0) - sum_ff) : sum_ff;
         rem_ff  <= '0;
         den_ff  <= den_pick;
         zero_ff <= (den_pick == '0);
         used_ff <= (count_wide > 32'd511) ? {USED_W{1'b1}} : count_wide[USED_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= fits ? WT_W'(trial - {1'b0, den_ff}) : trial[WT_W-1:0];
         quo_ff <= {quo_ff[QBITS-2:0], fits};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (item_ff.empty_row) begin
            rsp_ff.lag_value    <= '0;
            rsp_ff.used_count   <= '0;
            rsp_ff.zero_divisor <= 1'b1;
         end else begin
            rsp_ff.lag_value    <= zero_ff ? '0 : q_signed[VAL_W-1:0];
            rsp_ff.used_count   <= used_ff;
            rsp_ff.zero_divisor <= zero_ff;
         end
      end
   end

endmodule

>>> rtl/spatial_lag_row_average_core.sv
// ============================================================================
// spatial_lag_row_average_core: spatial lag of one sparse weights row
// Accumulates the neighbour elements of a row and divides once at row end.
// ============================================================================
// Each transaction on the req_ channel is one neighbour element; a row ends
// with last_element set, or an empty_row marker stands for a whole row. An
// element is captured, multiplied and accumulated; a row end then runs the
// restoring divider, which produces one of its 64 quotient bits per cycle;
// an empty-row marker skips to the result. The result waits in an output
// register, so the next row can start while it is still stalled; a row end
// finding that register still full waits until it drains. Products are
// exact (Q32.32), both accumulators saturate and the quotient truncates
// towards zero and saturates to 32 bits. Binary mode gives the mean of the
// used values; otherwise the weighted sum over the weight total. A zero
// divisor gives lag 0 with zero_divisor set. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module spatial_lag_row_average_core
   import slra_pkg::*;
#(
   parameter int unsigned ID_WIDTH      = 16,
   parameter int unsigned MAX_NEIGHBORS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  slra_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output slra_rsp_type         rsp_data
);

   slra_cmd_type    cmd;
   slra_status_type status;

   // Row controller
   slra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Row datapath
   slra_dp #(
      .ID_WIDTH      (ID_WIDTH),
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

   // An accepted transaction always makes the block busy, so it stalls the input before accepting another.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted in two consecutive cycles");

   // A zero divisor always yields a zero lag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_divisor) |-> (rsp_data.lag_value == '0))
      else $error("nonzero lag with zero divisor");

   // The used count never exceeds the neighbour limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.used_count) <= MAX_NEIGHBORS))
      else $error("used count above neighbour limit");

   // A new result is loaded only when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result loaded over a stalled transaction");

endmodule
